>>> rtl/rbfc_pkg.sv
// Shared constants and field widths for the ring byte FIFO with chunk access.
package rbfc_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int CHUNK_BYTES_DEF  = 8;

    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int FILL_W = 10;
    localparam int LANES  = DATA_W / 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

endpackage

>>> rtl/rbfc_if.sv
// Request and response channel interfaces of the ring byte FIFO.
interface rbfc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [rbfc_pkg::LEN_W-1:0]  chunk_length;
    logic [rbfc_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output op, output chunk_length, output data_in, input ready);
    modport sink   (input valid, input op, input chunk_length, input data_in, output ready);
endinterface

interface rbfc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [rbfc_pkg::DATA_W-1:0] data_out;
    logic [rbfc_pkg::FILL_W-1:0] fill_level;

    modport source (output valid, output accepted, output data_out, output fill_level,
                    input ready);
    modport sink   (input valid, input accepted, input data_out, input fill_level,
                    output ready);
endinterface

>>> rtl/ring_byte_fifo_chunk_access_top.sv
// Top level of the ring byte FIFO with chunk push and pop.
//
// Each request transaction pushes or pops a chunk of 1 to CHUNK_BYTES bytes and produces
// exactly one response transaction. The response passes through the memory read stage to
// the response register. A new request is taken every cycle when the response side does
// not stall: the request register, where space is checked, the pointers moved and the lane
// memory accesses issued, the memory read stage and the response register each hold one
// transaction, and each stage moves up whenever the one after it is free. The occupancy
// count and the pointers are updated as a request leaves the request register, which is
// the only dependency between back-to-back requests. Storage is eight byte-wide lane
// memories, each with one write and one registered read port, so a chunk is stored or
// fetched in one access whatever its alignment. Internally the byte store is sized to the
// power of two at or above BUFFER_BYTES; capacity stays BUFFER_BYTES - 1 bytes. The store
// needs no clearing after reset, since a pop only returns bytes written by an earlier push.
module ring_byte_fifo_chunk_access_top #(
    parameter int BUFFER_BYTES = rbfc_pkg::BUFFER_BYTES_DEF,
    parameter int CHUNK_BYTES  = rbfc_pkg::CHUNK_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    rbfc_req_if.sink        req,
    rbfc_rsp_if.source      rsp
);

    localparam int LN   = rbfc_pkg::LANES;
    localparam int DW   = rbfc_pkg::DATA_W;
    localparam int LW   = rbfc_pkg::LEN_W;
    localparam int CW   = $clog2(BUFFER_BYTES);
    localparam int LB   = $clog2(LN);
    localparam int RW   = CW - LB;
    localparam int ROWS = 2 ** RW;

    typedef logic [CW-1:0] ptr_t;
    typedef logic [RW-1:0] row_t;
    typedef logic [LB-1:0] bank_t;

    // request register
    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [LW-1:0]       s1_len_reg;
    logic [DW-1:0]       s1_data_reg;

    // pointers and occupancy
    ptr_t                wp_reg, wp_next;
    ptr_t                rp_reg, rp_next;
    ptr_t                cnt_reg, cnt_next;

    // memory read stage
    logic                s2_valid_reg;
    logic                s2_ok_reg;
    logic                s2_pop_reg;
    logic [LW-1:0]       s2_len_reg;
    bank_t               s2_bank_reg;
    ptr_t                s2_fill_reg;
    logic [DW-1:0]       rd_reg;

    // response register
    logic                out_valid_reg;
    logic                out_acc_reg;
    logic [DW-1:0]       out_data_reg;
    logic [rbfc_pkg::FILL_W-1:0] out_fill_reg;

    logic                en1, en2, en3, step;
    logic                len_ok, push_ok, pop_ok;
    logic [CW:0]         sum;
    bank_t               wbank, rbank;
    row_t                wrow, rrow;
    logic [2*DW-1:0]     wr_dbl;
    logic [DW-1:0]       wr_rot;
    logic [2*DW-1:0]     rd_dbl;
    logic [DW-1:0]       rd_rot;
    logic [DW-1:0]       out_data_next;

    assign en3       = !out_valid_reg || rsp.ready;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign req.ready = en1;
    assign step      = s1_valid_reg && en2;

    assign len_ok  = (s1_len_reg != '0) && (s1_len_reg <= LW'(CHUNK_BYTES));
    assign sum     = {1'b0, cnt_reg} + (CW+1)'(s1_len_reg);
    // one byte always stays free, so the chunk fits only if count + length < size
    assign push_ok = len_ok && (s1_op_reg == rbfc_pkg::OP_PUSH)
                     && (sum < (CW+1)'(BUFFER_BYTES));
    assign pop_ok  = len_ok && (s1_op_reg == rbfc_pkg::OP_POP)
                     && (cnt_reg >= CW'(s1_len_reg));

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push_ok)
        begin
            wp_next  = wp_reg + CW'(s1_len_reg);
            cnt_next = cnt_reg + CW'(s1_len_reg);
        end
        else if (pop_ok)
        begin
            rp_next  = rp_reg + CW'(s1_len_reg);
            cnt_next = cnt_reg - CW'(s1_len_reg);
        end
    end

    assign wbank = wp_reg[LB-1:0];
    assign wrow  = wp_reg[CW-1:LB];
    assign rbank = rp_reg[LB-1:0];
    assign rrow  = rp_reg[CW-1:LB];

    // lane b takes chunk byte (b - wbank) mod LANES
    assign wr_dbl = {s1_data_reg, s1_data_reg} << {wbank, 3'b000};
    assign wr_rot = wr_dbl[2*DW-1:DW];

    for (genvar b = 0; b < LN; b++)
    begin : g_lane
        localparam bank_t LANE = LB'(b);
        logic [7:0] mem [ROWS];
        bank_t      woff;
        logic       we;
        row_t       wr_row;
        row_t       rd_row;

        assign woff   = LANE - wbank;
        assign we     = step && push_ok && (LW'(woff) < s1_len_reg);
        // lanes below the start lane belong to the next row
        assign wr_row = wrow + RW'(LANE < wbank);
        assign rd_row = rrow + RW'(LANE < rbank);

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[wr_row] <= wr_rot[8*b +: 8];
            end
            if (step && pop_ok)
            begin
                rd_reg[8*b +: 8] <= mem[rd_row];
            end
        end
    end

    assign rd_dbl = {rd_reg, rd_reg} >> {s2_bank_reg, 3'b000};
    assign rd_rot = rd_dbl[DW-1:0];

    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < LN; i++)
        begin
            if (s2_ok_reg && s2_pop_reg && (LW'(i) < s2_len_reg))
            begin
                out_data_next[8*i +: 8] = rd_rot[8*i +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (step)
            begin
                wp_reg  <= wp_next;
                rp_reg  <= rp_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && req.valid)
        begin
            s1_op_reg   <= req.op;
            s1_len_reg  <= req.chunk_length;
            s1_data_reg <= req.data_in;
        end
        if (step)
        begin
            s2_ok_reg   <= push_ok || pop_ok;
            s2_pop_reg  <= (s1_op_reg == rbfc_pkg::OP_POP);
            s2_len_reg  <= s1_len_reg;
            s2_bank_reg <= rbank;
            s2_fill_reg <= cnt_next;
        end
        if (en3 && s2_valid_reg)
        begin
            out_acc_reg  <= s2_ok_reg;
            out_data_reg <= out_data_next;
            out_fill_reg <= rbfc_pkg::FILL_W'(s2_fill_reg);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.accepted   = out_acc_reg;
    assign rsp.data_out   = out_data_reg;
    assign rsp.fill_level = out_fill_reg;

endmodule

>>> rtl/rbfc_checker.sv
// Port-level assertions for the ring byte FIFO, bound to the top level.
module rbfc_checker #(
    parameter int BUFFER_BYTES = rbfc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic                        accepted,
    input  logic [rbfc_pkg::DATA_W-1:0] data_out,
    input  logic [rbfc_pkg::FILL_W-1:0] fill_level
);

    // transactions in flight between request and response side
    logic [2:0] outst_reg, outst_next;

    assign outst_next = outst_reg + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted)
            && $stable(data_out) && $stable(fill_level))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outst_reg != 3'd0)
        else $error("response without a pending request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg <= 3'd3)
        else $error("more transactions in flight than pipeline stages");

    a_data_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (data_out != '0) |-> accepted)
        else $error("data returned for a rejected request");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (BUFFER_BYTES > 1024) || (int'(fill_level) <= BUFFER_BYTES - 1))
        else $error("fill level beyond capacity");

endmodule

bind ring_byte_fifo_chunk_access_top rbfc_checker #(
    .BUFFER_BYTES (BUFFER_BYTES)
) u_rbfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .accepted   (rsp.accepted),
    .data_out   (rsp.data_out),
    .fill_level (rsp.fill_level)
);
